// ----- rtl/core/msp2fp_pkg.sv -----
// Shared types, codes and the CRC-8 step for the MSPv2 frame parser.
`timescale 1ns / 1ps

package msp2fp_pkg;

    localparam int HEADER_BYTES = 5;

    localparam logic [7:0] CRC_POLY  = 8'hD5;
    localparam logic [7:0] CHAR_SYNC = 8'h24;  // '$'
    localparam logic [7:0] CHAR_V2   = 8'h58;  // 'X'
    localparam logic [7:0] CHAR_CMD  = 8'h3C;  // '<'
    localparam logic [7:0] CHAR_RSP  = 8'h3E;  // '>'

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_ABORT = 1'b1;

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_HEADER  = 3'd1;
    localparam logic [2:0] EV_PAYLOAD = 3'd2;
    localparam logic [2:0] EV_GOOD    = 3'd3;
    localparam logic [2:0] EV_BAD_CRC = 3'd4;

    localparam logic [1:0] KIND_UNKNOWN  = 2'd0;
    localparam logic [1:0] KIND_COMMAND  = 2'd1;
    localparam logic [1:0] KIND_RESPONSE = 2'd2;

    localparam int RES_USER_W = 6;
    localparam int RES_DATA_W = 80;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic        claimed;
        logic [2:0]  event_res;
        logic [1:0]  frame_kind;
        logic [7:0]  frame_flags;
        logic [15:0] function_code;
        logic [15:0] payload_length;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [7:0]  received_crc;
        logic [7:0]  computed_crc;
    } result_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] v;
        v = acc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

// ----- rtl/core/msp2fp_in_stage.sv -----
// Input register stage holding one received transaction.
`timescale 1ns / 1ps

module msp2fp_in_stage
    import msp2fp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    output logic     q_valid,
    input  logic     q_ready,
    output in_item_t q_item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_ready    = !valid_reg || q_ready;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

    assign q_valid = valid_reg;
    assign q_item  = item_reg;

endmodule

// ----- rtl/core/msp2fp_parser.sv -----
// Frame state machine, header capture and CRC-8 accumulation.
`timescale 1ns / 1ps

module msp2fp_parser
    import msp2fp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     advance,
    input  in_item_t item,
    output result_t  res
);

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_START   = 6'b000010,
        PH_X       = 6'b000100,
        PH_HEADER  = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_CHECK   = 6'b100000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  crc_reg, crc_next;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  flags_reg, flags_next;
    logic [15:0] func_reg, func_next;
    logic [15:0] len_reg, len_next;

    logic [15:0] count_inc;
    logic [7:0]  crc_upd;
    logic [7:0]  b;
    logic        took;

    assign b         = item.rx_byte;
    assign count_inc = count_reg + 16'd1;
    assign crc_upd   = crc8_step(crc_reg, b);

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        crc_next   = crc_reg;
        kind_next  = kind_reg;
        flags_next = flags_reg;
        func_next  = func_reg;
        len_next   = len_reg;
        took       = 1'b0;
        res        = '0;
        if (item.operation == OP_ABORT) begin
            phase_next = PH_IDLE;
        end else begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (b == CHAR_SYNC) begin
                        phase_next = PH_START;
                        took       = 1'b1;
                    end
                end
                PH_START: begin
                    phase_next = (b == CHAR_V2) ? PH_X : PH_IDLE;
                end
                PH_X: begin
                    flags_next = '0;
                    func_next  = '0;
                    len_next   = '0;
                    count_next = '0;
                    crc_next   = '0;
                    phase_next = PH_HEADER;
                    if (b == CHAR_CMD) begin
                        kind_next = KIND_COMMAND;
                    end else if (b == CHAR_RSP) begin
                        kind_next = KIND_RESPONSE;
                    end else begin
                        kind_next  = KIND_UNKNOWN;
                        phase_next = PH_IDLE;
                    end
                end
                PH_HEADER: begin
                    crc_next = crc_upd;
                    case (count_reg)
                        16'd0:   flags_next = b;
                        16'd1:   func_next  = {func_reg[15:8], b};
                        16'd2:   func_next  = {b, func_reg[7:0]};
                        16'd3:   len_next   = {len_reg[15:8], b};
                        default: len_next   = {b, len_reg[7:0]};
                    endcase
                    count_next = count_inc;
                    if (count_inc >= 16'(HEADER_BYTES)) begin
                        count_next    = '0;
                        res.event_res = EV_HEADER;
                        phase_next    = (len_next == 16'd0) ? PH_CHECK : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    crc_next          = crc_upd;
                    res.event_res     = EV_PAYLOAD;
                    res.payload_byte  = b;
                    res.payload_index = count_reg;
                    count_next        = count_inc;
                    if (count_inc == len_reg) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    took             = 1'b1;
                    phase_next       = PH_IDLE;
                    res.received_crc = b;
                    res.event_res    = (b == crc_reg) ? EV_GOOD : EV_BAD_CRC;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        res.claimed        = took || (phase_next != PH_IDLE);
        res.frame_kind     = kind_next;
        res.frame_flags    = flags_next;
        res.function_code  = func_next;
        res.payload_length = len_next;
        res.computed_crc   = crc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            crc_reg   <= '0;
            kind_reg  <= KIND_UNKNOWN;
            flags_reg <= '0;
            func_reg  <= '0;
            len_reg   <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            crc_reg   <= crc_next;
            kind_reg  <= kind_next;
            flags_reg <= flags_next;
            func_reg  <= func_next;
            len_reg   <= len_next;
        end
    end

`ifndef SYNTHESIS
    a_abort_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.operation == OP_ABORT |=> phase_reg == PH_IDLE)
        else $error("abort did not return parser to idle");

    a_check_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (res.event_res == EV_GOOD || res.event_res == EV_BAD_CRC)
        |=> phase_reg == PH_IDLE)
        else $error("checksum byte did not close the frame");

    a_empty_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res.event_res == EV_HEADER && res.payload_length == 16'd0
        |=> phase_reg == PH_CHECK)
        else $error("empty payload did not go to checksum");

    a_payload_count: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res.event_res == EV_PAYLOAD
        |=> count_reg == $past(count_reg) + 16'd1)
        else $error("payload index did not advance");
`endif

endmodule

// ----- rtl/core/msp2fp_out_stage.sv -----
// Result register driving the master-side stream.
`timescale 1ns / 1ps

module msp2fp_out_stage
    import msp2fp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    r_valid,
    output logic    r_ready,
    input  result_t r_res,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign r_ready    = !valid_reg || m_ready;
    assign valid_next = r_ready ? r_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (r_ready && r_valid) begin
            res_reg <= r_res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

// ----- rtl/core/mspv2_frame_parser.sv -----
// Top level of the MSPv2 frame parser with CRC-8 DVB-S2 check.
// One received byte (or an abort) enters per transaction, one result leaves per transaction.
// The block takes one transaction per cycle when the output side keeps up; a transaction passes
// through the input register and then the result register. The frame state machine
// and an eight-step unrolled CRC-8 sit between those two registers. s_tready follows m_tready
// combinationally when both registers are full. Payload bytes stream out with their index.
`timescale 1ns / 1ps

module mspv2_frame_parser
    import msp2fp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // rx_byte
    input  logic                  s_tuser,   // operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // frame_flags, function_code, payload_length, payload_byte, payload_index,
    // received_crc, computed_crc
    output logic [RES_DATA_W-1:0] m_tdata,
    output logic [RES_USER_W-1:0] m_tuser    // claimed, event_res, frame_kind
);

    in_item_t s_item;
    in_item_t q_item;
    logic     q_valid;
    logic     q_ready;
    result_t  step_res;
    result_t  m_res;

    assign s_item.operation = s_tuser;
    assign s_item.rx_byte   = s_tdata;

    msp2fp_in_stage u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    msp2fp_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (q_valid && q_ready),
        .item    (q_item),
        .res     (step_res)
    );

    msp2fp_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .r_valid (q_valid),
        .r_ready (q_ready),
        .r_res   (step_res),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (m_res)
    );

    assign m_tuser = {m_res.frame_kind, m_res.event_res, m_res.claimed};
    assign m_tdata = {m_res.computed_crc, m_res.received_crc, m_res.payload_index,
                      m_res.payload_byte, m_res.payload_length, m_res.function_code,
                      m_res.frame_flags};

endmodule

// ----- bench/tb_mspv2_frame_parser.sv -----
// Self-checking stream testbench for the MSPv2 frame parser.
`timescale 1ns / 1ps

module tb_mspv2_frame_parser;
    import msp2fp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GOT_SYNC,
        ST_GOT_V2,
        ST_HEADER,
        ST_PAYLOAD,
        ST_CHECKSUM
    } parse_state_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;      // rx_byte
    logic                  s_tuser = OP_BYTE; // operation
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // frame_flags, function_code, payload_length, payload_byte, payload_index,
    // received_crc, computed_crc
    logic [RES_DATA_W-1:0] m_tdata;
    logic [RES_USER_W-1:0] m_tuser;           // claimed, event_res, frame_kind

    in_item_t     rx_stream[$];
    result_t      expected_results[$];

    parse_state_t frame_state = ST_IDLE;
    logic [15:0]  byte_cnt = '0;
    logic [7:0]   running_crc = '0;
    logic [1:0]   kind_q = KIND_UNKNOWN;
    logic [7:0]   flags_q = '0;
    logic [15:0]  function_q = '0;
    logic [15:0]  length_q = '0;

    int           send_wait = 0;
    int           recv_wait = 0;
    int unsigned  cycle_cnt = 0;
    logic         hold_off;
    logic         quiet;
    in_item_t     next_item;

    int           err_cnt = 0;
    int           n_sent = 0;
    int           n_checked = 0;
    int           n_headers = 0;
    int           n_payload = 0;
    int           n_good = 0;
    int           n_bad_crc = 0;
    int           n_aborts = 0;

    mspv2_frame_parser uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 aclk = ~aclk;

    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
        logic fb;
        int   i;
        for (i = 7; i >= 0; i--) begin
            fb  = acc[7] ^ b[i];
            acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return acc;
    endfunction

    function automatic result_t parse_byte(input logic op, input logic [7:0] c);
        result_t r;
        logic    took;
        r    = '0;
        took = 1'b0;
        if (op == OP_ABORT) begin
            frame_state = ST_IDLE;
        end else begin
            case (frame_state)
                ST_IDLE: begin
                    if (c == CHAR_SYNC) begin
                        frame_state = ST_GOT_SYNC;
                        took        = 1'b1;
                    end
                end
                ST_GOT_SYNC: begin
                    frame_state = (c == CHAR_V2) ? ST_GOT_V2 : ST_IDLE;
                end
                ST_GOT_V2: begin
                    flags_q     = '0;
                    function_q  = '0;
                    length_q    = '0;
                    byte_cnt    = '0;
                    running_crc = '0;
                    frame_state = ST_HEADER;
                    if (c == CHAR_CMD) begin
                        kind_q = KIND_COMMAND;
                    end else if (c == CHAR_RSP) begin
                        kind_q = KIND_RESPONSE;
                    end else begin
                        kind_q      = KIND_UNKNOWN;
                        frame_state = ST_IDLE;
                    end
                end
                ST_HEADER: begin
                    running_crc = crc8_next(running_crc, c);
                    case (byte_cnt)
                        16'd0:   flags_q = c;
                        16'd1:   function_q[7:0] = c;
                        16'd2:   function_q[15:8] = c;
                        16'd3:   length_q[7:0] = c;
                        default: length_q[15:8] = c;
                    endcase
                    byte_cnt = byte_cnt + 16'd1;
                    if (byte_cnt >= HEADER_BYTES) begin
                        byte_cnt    = '0;
                        r.event_res = EV_HEADER;
                        frame_state = (length_q == 16'd0) ? ST_CHECKSUM : ST_PAYLOAD;
                    end
                end
                ST_PAYLOAD: begin
                    running_crc     = crc8_next(running_crc, c);
                    r.event_res     = EV_PAYLOAD;
                    r.payload_byte  = c;
                    r.payload_index = byte_cnt;
                    byte_cnt        = byte_cnt + 16'd1;
                    if (byte_cnt == length_q) begin
                        frame_state = ST_CHECKSUM;
                    end
                end
                ST_CHECKSUM: begin
                    took           = 1'b1;
                    frame_state    = ST_IDLE;
                    r.received_crc = c;
                    r.event_res    = (c == running_crc) ? EV_GOOD : EV_BAD_CRC;
                end
                default: begin
                    frame_state = ST_IDLE;
                end
            endcase
        end
        r.claimed        = took || (frame_state != ST_IDLE);
        r.frame_kind     = kind_q;
        r.frame_flags    = flags_q;
        r.function_code  = function_q;
        r.payload_length = length_q;
        r.computed_crc   = running_crc;
        return r;
    endfunction

    task automatic add_byte(input logic [7:0] c);
        in_item_t it;
        it.operation = OP_BYTE;
        it.rx_byte   = c;
        rx_stream.push_back(it);
    endtask

    task automatic add_abort();
        in_item_t it;
        it.operation = OP_ABORT;
        it.rx_byte   = 8'($urandom);
        rx_stream.push_back(it);
    endtask

    // cut < 0 sends the whole frame; otherwise send the first cut bytes (at most the whole frame), then an abort
    task automatic add_frame(input logic [7:0] kind_ch, input logic [7:0] fl,
                             input logic [15:0] fn, input logic [15:0] len,
                             input int cut, input bit corrupt);
        logic [7:0] fb[$];
        logic [7:0] acc;
        logic [7:0] b;
        int         i;
        fb.push_back(CHAR_SYNC);
        fb.push_back(CHAR_V2);
        fb.push_back(kind_ch);
        fb.push_back(fl);
        fb.push_back(fn[7:0]);
        fb.push_back(fn[15:8]);
        fb.push_back(len[7:0]);
        fb.push_back(len[15:8]);
        acc = '0;
        for (i = 3; i < 8; i++) begin
            acc = crc8_next(acc, fb[i]);
        end
        for (i = 0; i < len && (cut < 0 || fb.size() < cut); i++) begin
            b = 8'($urandom);
            fb.push_back(b);
            acc = crc8_next(acc, b);
        end
        fb.push_back(corrupt ? (acc ^ 8'($urandom_range(1, 255))) : acc);
        for (i = 0; i < fb.size() && (cut < 0 || i < cut); i++) begin
            add_byte(fb[i]);
        end
        if (cut >= 0) begin
            add_abort();
        end
    endtask

    task automatic add_random_frame(input int cut, input bit corrupt);
        logic [15:0] len;
        len = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(13, 64))
                                           : 16'($urandom_range(0, 12));
        add_frame($urandom_range(0, 1) ? CHAR_CMD : CHAR_RSP, 8'($urandom), 16'($urandom),
                  len, cut, corrupt);
    endtask

    task automatic check_result(input result_t got, input result_t want);
        if (got.claimed !== want.claimed) begin
            $error("claimed: expected %0d, got %0d", want.claimed, got.claimed);
            err_cnt++;
        end
        if (got.event_res !== want.event_res) begin
            $error("event_res: expected %0d, got %0d", want.event_res, got.event_res);
            err_cnt++;
        end
        if (got.frame_kind !== want.frame_kind) begin
            $error("frame_kind: expected %0d, got %0d", want.frame_kind, got.frame_kind);
            err_cnt++;
        end
        if (got.frame_flags !== want.frame_flags) begin
            $error("frame_flags: expected %h, got %h", want.frame_flags, got.frame_flags);
            err_cnt++;
        end
        if (got.function_code !== want.function_code) begin
            $error("function_code: expected %h, got %h",
                   want.function_code, got.function_code);
            err_cnt++;
        end
        if (got.payload_length !== want.payload_length) begin
            $error("payload_length: expected %h, got %h",
                   want.payload_length, got.payload_length);
            err_cnt++;
        end
        if (got.payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %h, got %h", want.payload_byte, got.payload_byte);
            err_cnt++;
        end
        if (got.payload_index !== want.payload_index) begin
            $error("payload_index: expected %h, got %h",
                   want.payload_index, got.payload_index);
            err_cnt++;
        end
        if (got.received_crc !== want.received_crc) begin
            $error("received_crc: expected %h, got %h", want.received_crc, got.received_crc);
            err_cnt++;
        end
        if (got.computed_crc !== want.computed_crc) begin
            $error("computed_crc: expected %h, got %h", want.computed_crc, got.computed_crc);
            err_cnt++;
        end
        case (want.event_res)
            EV_HEADER:  n_headers++;
            EV_PAYLOAD: n_payload++;
            EV_GOOD:    n_good++;
            EV_BAD_CRC: n_bad_crc++;
            default:    ;
        endcase
    endtask

    // Cycle count drives the long receiver hold-off and the no-idle stretches
    always @(posedge aclk) begin
        if (!aresetn) begin
            cycle_cnt <= 0;
        end else begin
            cycle_cnt <= cycle_cnt + 1;
        end
    end

    assign hold_off = (cycle_cnt >= 1000) && (cycle_cnt < 1120);
    assign quiet    = (cycle_cnt[9:8] == 2'b11);

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_wait = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(parse_byte(s_tuser, s_tdata));
                n_sent++;
                if (s_tuser == OP_ABORT) begin
                    n_aborts++;
                end
                send_wait = quiet ? 0 : $urandom_range(0, 5);
            end else if (!s_tvalid && send_wait > 0) begin
                send_wait--;
            end
            if (s_tvalid && !s_tready) begin
                // hold the offered transaction
            end else if (send_wait == 0 && rx_stream.size() > 0) begin
                next_item = rx_stream.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_item.rx_byte;
                s_tuser  <= next_item.operation;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_checked++;
                if (expected_results.size() == 0) begin
                    $error("result transaction with no expected result pending");
                    err_cnt++;
                end else begin
                    check_result(result_t'({m_tuser[0], m_tuser[3:1], m_tuser[5:4],
                                            m_tdata[7:0], m_tdata[23:8], m_tdata[39:24],
                                            m_tdata[47:40], m_tdata[63:48],
                                            m_tdata[71:64], m_tdata[79:72]}),
                                 expected_results.pop_front());
                end
                recv_wait = quiet ? 0 : $urandom_range(0, 5);
            end else if (!m_tready && recv_wait > 0) begin
                recv_wait--;
            end
            m_tready <= (recv_wait == 0) && !hold_off;
        end
    end

    initial begin
        #3_000_000;
        $display("FAIL mspv2_frame_parser");
        $finish;
    end

    initial begin
        logic [7:0] b;
        int         pick;

        add_frame(CHAR_CMD, 8'hFF, 16'hFFFF, 16'h0000, -1, 1'b0);
        add_frame(CHAR_RSP, 8'h00, 16'h0000, 16'h0000, -1, 1'b1);
        add_byte(CHAR_SYNC);
        add_byte(8'h41);
        add_byte(CHAR_SYNC);
        add_byte(CHAR_V2);
        add_byte(8'h5A);
        add_frame(CHAR_CMD, 8'h5A, 16'h1234, 16'h0002, 4, 1'b0);

        add_frame(CHAR_RSP, 8'($urandom), 16'($urandom), 16'd300, -1, 1'b0);
        add_frame(CHAR_CMD, 8'($urandom), 16'($urandom), 16'hFFFF, 48, 1'b0);

        while (rx_stream.size() < 1800) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                add_random_frame(-1, $urandom_range(0, 7) == 0);
            end else if (pick < 78) begin
                add_random_frame($urandom_range(1, 12), 1'b0);
            end else if (pick < 84) begin
                add_byte(CHAR_SYNC);
                add_byte(CHAR_V2);
                do b = 8'($urandom); while (b == CHAR_CMD || b == CHAR_RSP);
                add_byte(b);
            end else if (pick < 88) begin
                add_byte(CHAR_SYNC);
                do b = 8'($urandom); while (b == CHAR_V2);
                add_byte(b);
            end else if (pick < 92) begin
                add_abort();
            end else begin
                repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
                if ($urandom_range(0, 1) == 1) begin
                    add_abort();
                end
            end
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (rx_stream.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Checked %0d results for %0d input transactions, %0d of them aborts.",
                 n_checked, n_sent, n_aborts);
        $display("Saw %0d headers, %0d payload bytes, %0d good frames, %0d checksum errors.",
                 n_headers, n_payload, n_good, n_bad_crc);
        if (err_cnt == 0) begin
            $display("PASS mspv2_frame_parser");
        end else begin
            $display("FAIL mspv2_frame_parser");
        end
        $finish;
    end

endmodule

// ----- mspv2_frame_parser.f -----
rtl/core/msp2fp_pkg.sv
rtl/core/msp2fp_in_stage.sv
rtl/core/msp2fp_parser.sv
rtl/core/msp2fp_out_stage.sv
rtl/core/mspv2_frame_parser.sv
bench/tb_mspv2_frame_parser.sv
